### hdl/ibfd_pkg.sv
// Package for the iBus frame decoder: payload structs, codes, widths and defaults.
// Depends on nothing; the front end, back end, top level, checker and bench use it.
`timescale 1ns / 1ps

package ibfd_pkg;

  localparam int unsigned CHANNEL_COUNT_DEFAULT = 10;
  localparam int unsigned FRAME_BYTES_DEFAULT   = 32;
  localparam int unsigned QUEUE_DEPTH_DEFAULT   = 2;

  localparam int unsigned CHANNEL_W   = 16;
  localparam int unsigned CH_SUM_W    = 20;
  localparam int unsigned ERROR_W     = 32;
  localparam int unsigned INDEX_W     = 4;
  localparam int unsigned COUNT_W     = 6;
  localparam int unsigned CFG_DATA_W  = 20;

  localparam logic [CH_SUM_W-1:0]  THRESHOLD_RESET = 20'd9000;
  localparam logic [CHANNEL_W-1:0] OFFSET_RESET    = 16'd1000;

  typedef enum logic {
    OP_DATA_BYTE    = 1'b0,
    OP_END_OF_FRAME = 1'b1
  } op_e;

  typedef enum logic {
    REG_ACTIVE_THRESHOLD = 1'b0,
    REG_CHANNEL_OFFSET   = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0]   channel_index;
    logic [CHANNEL_W-1:0] channel_value;
    logic                 remote_active;
    logic                 frame_accepted;
    logic [ERROR_W-1:0]   error_total;
    logic                 last_channel;
  } out_item_t;

  typedef struct packed {
    logic               active;
    logic               accepted;
    logic [ERROR_W-1:0] errors;
  } report_t;

endpackage

### hdl/ibfd_stream_if.sv
// Valid/ready stream interface of the iBus frame decoder, payload type as parameter.
// Depends on nothing; payload structs come from ibfd_pkg at the point of use.
`timescale 1ns / 1ps

interface ibfd_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

### hdl/ibfd_front.sv
// Front end of the iBus frame decoder: byte capture, running sums and frame verdict.
// Depends on ibfd_pkg and ibfd_stream_if; pushes one report per end-of-frame request.
`timescale 1ns / 1ps

module ibfd_front #(
  parameter int unsigned CHANNEL_COUNT = ibfd_pkg::CHANNEL_COUNT_DEFAULT,
  parameter int unsigned FRAME_BYTES   = ibfd_pkg::FRAME_BYTES_DEFAULT
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  ibfd_stream_if.sink                                    in_s,
  input  logic [ibfd_pkg::CH_SUM_W-1:0]                  threshold_i,
  input  logic                                           queue_full_i,
  output logic                                           push_o,
  output ibfd_pkg::report_t                              push_report_o,
  output logic [CHANNEL_COUNT-1:0][ibfd_pkg::CHANNEL_W-1:0] push_channels_o
);

  localparam int unsigned CW = ibfd_pkg::COUNT_W;
  localparam int unsigned SW = ibfd_pkg::CH_SUM_W;
  localparam int unsigned DW = ibfd_pkg::CHANNEL_W;
  localparam logic [CW-1:0] COUNT_MAX = '1;
  localparam logic [CW-1:0] FRAME_LEN = CW'(FRAME_BYTES);
  localparam logic [CW-1:0] CSUM_LO   = CW'(FRAME_BYTES - 2);
  localparam logic [CW-1:0] CSUM_HI   = CW'(FRAME_BYTES - 1);
  localparam logic [CW-1:0] CAP_START = CW'(2);
  localparam logic [CW-1:0] CAP_END   = CW'(2 + 2 * CHANNEL_COUNT);

  logic [CW-1:0]                    count_q, count_d;
  logic [DW-1:0]                    rsum_q, rsum_d;
  logic [SW-1:0]                    ssum_q, ssum_d;
  logic [DW-1:0]                    csum_q, csum_d;
  logic [CHANNEL_COUNT-1:0][DW-1:0] shadow_q, shadow_d;
  logic [CHANNEL_COUNT-1:0][DW-1:0] stored_q, stored_d;
  logic [SW-1:0]                    stsum_q, stsum_d;
  logic [ibfd_pkg::ERROR_W-1:0]     reject_q, reject_d;

  logic                         take;
  logic                         is_end;
  logic [7:0]                   b;
  logic [CW-1:0]                pos_off;
  logic                         accepted;
  logic [SW-1:0]                new_sum;
  logic [ibfd_pkg::ERROR_W-1:0] err_next;

  assign in_s.ready = !queue_full_i;
  assign take       = in_s.valid && in_s.ready;
  assign is_end     = in_s.payload.operation == ibfd_pkg::OP_END_OF_FRAME;
  assign b          = in_s.payload.data_byte;
  assign pos_off    = count_q - CAP_START;
  assign accepted   = (count_q == FRAME_LEN) && (~rsum_q == csum_q);
  assign new_sum    = accepted ? ssum_q : stsum_q;
  assign err_next   = (!accepted && (reject_q != '1)) ? reject_q + 1'b1 : reject_q;

  always_comb begin
    count_d  = count_q;
    rsum_d   = rsum_q;
    ssum_d   = ssum_q;
    csum_d   = csum_q;
    shadow_d = shadow_q;
    stored_d = stored_q;
    stsum_d  = stsum_q;
    reject_d = reject_q;
    if (take && is_end) begin
      if (accepted) begin
        stored_d = shadow_q;
        stsum_d  = ssum_q;
      end
      reject_d = err_next;
      count_d  = '0;
      rsum_d   = '0;
      ssum_d   = '0;
    end else if (take && (count_q != COUNT_MAX)) begin
      if (count_q < CSUM_LO) begin
        rsum_d = rsum_q + DW'(b);
      end
      if ((count_q >= CAP_START) && (count_q < CAP_END)) begin
        if (pos_off[0]) begin
          ssum_d = ssum_q + {(SW-DW)'(0), b, 8'h00};
        end else begin
          ssum_d = ssum_q + SW'(b);
        end
        for (int i = 0; i < CHANNEL_COUNT; i++) begin
          if (pos_off[CW-1:1] == (CW-1)'(i)) begin
            if (pos_off[0]) begin
              shadow_d[i][15:8] = b;
            end else begin
              shadow_d[i][7:0] = b;
            end
          end
        end
      end
      if (count_q == CSUM_LO) begin
        csum_d[7:0] = b;
      end
      if (count_q == CSUM_HI) begin
        csum_d[15:8] = b;
      end
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      rsum_q   <= '0;
      ssum_q   <= '0;
      csum_q   <= '0;
      stored_q <= '0;
      stsum_q  <= '0;
      reject_q <= '0;
    end else begin
      count_q  <= count_d;
      rsum_q   <= rsum_d;
      ssum_q   <= ssum_d;
      csum_q   <= csum_d;
      stored_q <= stored_d;
      stsum_q  <= stsum_d;
      reject_q <= reject_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shadow_q <= shadow_d;
  end

  assign push_o                 = take && is_end;
  assign push_report_o.active   = new_sum >= threshold_i;
  assign push_report_o.accepted = accepted;
  assign push_report_o.errors   = err_next;
  assign push_channels_o        = accepted ? shadow_q : stored_q;

endmodule

### hdl/ibfd_queue.sv
// Short report queue between front and back end of the iBus frame decoder.
// Depends on ibfd_pkg only through the widths handed in by the top level.
`timescale 1ns / 1ps

module ibfd_queue #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output logic [DATA_W-1:0] head_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              do_push;
  logic              do_pop;

  assign full_o  = cnt_q == CNT_FULL;
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### hdl/ibfd_back.sv
// Back end of the iBus frame decoder: walks one queued report out as channel results.
// Depends on ibfd_pkg and ibfd_stream_if; takes the offset from the top level.
`timescale 1ns / 1ps

module ibfd_back #(
  parameter int unsigned CHANNEL_COUNT = ibfd_pkg::CHANNEL_COUNT_DEFAULT
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              head_valid_i,
  input  ibfd_pkg::report_t                                 head_report_i,
  input  logic [CHANNEL_COUNT-1:0][ibfd_pkg::CHANNEL_W-1:0] head_channels_i,
  input  logic [ibfd_pkg::CHANNEL_W-1:0]                    offset_i,
  output logic                                              pop_o,
  ibfd_stream_if.source                                     out_s
);

  localparam int unsigned IW = ibfd_pkg::INDEX_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(CHANNEL_COUNT - 1);

  logic [IW-1:0]                  idx_q, idx_d;
  logic [ibfd_pkg::CHANNEL_W-1:0] sel;
  logic                           last;
  logic                           fire;

  always_comb begin
    sel = '0;
    for (int i = 0; i < CHANNEL_COUNT; i++) begin
      if (idx_q == IW'(i)) begin
        sel = head_channels_i[i];
      end
    end
  end

  assign last  = idx_q == LAST_IDX;
  assign fire  = out_s.valid && out_s.ready;
  assign pop_o = fire && last;

  always_comb begin
    idx_d = idx_q;
    if (fire) begin
      idx_d = last ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  assign out_s.valid                  = head_valid_i;
  assign out_s.payload.channel_index  = idx_q;
  assign out_s.payload.channel_value  = sel - offset_i;
  assign out_s.payload.remote_active  = head_report_i.active;
  assign out_s.payload.frame_accepted = head_report_i.accepted;
  assign out_s.payload.error_total    = head_report_i.errors;
  assign out_s.payload.last_channel   = last;

endmodule

### hdl/ibus_frame_decoder.sv
// iBus frame decoder: takes one request per cycle (a received byte or an
// end-of-frame marker) whenever the report queue has room. Each taken byte
// updates the frame count, checksum and channel capture registers. Each marker
// queues one report, and the back end then delivers one channel result per
// cycle while the result stream is ready; the input stalls only while
// QUEUE_DEPTH reports are waiting. There is no clearing pass.
// Top level; depends on ibfd_pkg, ibfd_stream_if, ibfd_front, ibfd_queue, ibfd_back.
`timescale 1ns / 1ps

module ibus_frame_decoder #(
  parameter int unsigned CHANNEL_COUNT = ibfd_pkg::CHANNEL_COUNT_DEFAULT,
  parameter int unsigned FRAME_BYTES   = ibfd_pkg::FRAME_BYTES_DEFAULT,
  parameter int unsigned QUEUE_DEPTH   = ibfd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  ibfd_stream_if.sink                     in_i,
  ibfd_stream_if.source                   out_o,
  input  logic                            cfg_we_i,
  input  logic                            cfg_index_i,
  input  logic [ibfd_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned CH_BITS = CHANNEL_COUNT * ibfd_pkg::CHANNEL_W;
  localparam int unsigned ENTRY_W = $bits(ibfd_pkg::report_t) + CH_BITS;

  logic [ibfd_pkg::CH_SUM_W-1:0]  threshold_q;
  logic [ibfd_pkg::CHANNEL_W-1:0] offset_q;

  logic                                              push;
  ibfd_pkg::report_t                                 push_report;
  logic [CHANNEL_COUNT-1:0][ibfd_pkg::CHANNEL_W-1:0] push_channels;
  logic                                              queue_full;
  logic                                              queue_empty;
  logic                                              pop;
  logic [ENTRY_W-1:0]                                head;
  ibfd_pkg::report_t                                 head_report;
  logic [CHANNEL_COUNT-1:0][ibfd_pkg::CHANNEL_W-1:0] head_channels;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= ibfd_pkg::THRESHOLD_RESET;
      offset_q    <= ibfd_pkg::OFFSET_RESET;
    end else if (cfg_we_i) begin
      unique case (ibfd_pkg::cfg_reg_e'(cfg_index_i))
        ibfd_pkg::REG_ACTIVE_THRESHOLD: threshold_q <= cfg_data_i;
        ibfd_pkg::REG_CHANNEL_OFFSET:   offset_q    <= cfg_data_i[ibfd_pkg::CHANNEL_W-1:0];
        default: ;
      endcase
    end
  end

  ibfd_front #(
    .CHANNEL_COUNT (CHANNEL_COUNT),
    .FRAME_BYTES   (FRAME_BYTES)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_s            (in_i),
    .threshold_i     (threshold_q),
    .queue_full_i    (queue_full),
    .push_o          (push),
    .push_report_o   (push_report),
    .push_channels_o (push_channels)
  );

  ibfd_queue #(
    .DATA_W (ENTRY_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_report, push_channels}),
    .full_o      (queue_full),
    .pop_i       (pop),
    .empty_o     (queue_empty),
    .head_o      (head)
  );

  assign head_report   = head[ENTRY_W-1:CH_BITS];
  assign head_channels = head[CH_BITS-1:0];

  ibfd_back #(
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (!queue_empty),
    .head_report_i   (head_report),
    .head_channels_i (head_channels),
    .offset_i        (offset_q),
    .pop_o           (pop),
    .out_s           (out_o)
  );

endmodule

### hdl/ibfd_checker.sv
// Port-level checks for the iBus frame decoder result stream, bound to the top level.
// Depends on ibfd_pkg and on the ports of ibus_frame_decoder.
`timescale 1ns / 1ps

module ibfd_checker #(
  parameter int unsigned CHANNEL_COUNT = ibfd_pkg::CHANNEL_COUNT_DEFAULT
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input ibfd_pkg::out_item_t out_payload_i
);

  localparam logic [ibfd_pkg::INDEX_W-1:0] LAST_IDX = ibfd_pkg::INDEX_W'(CHANNEL_COUNT - 1);

  logic fire_mid;
  assign fire_mid = out_valid_i && out_ready_i && !out_payload_i.last_channel;

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_payload_i))
    else $error("stalled result changed or dropped");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_payload_i.last_channel == (out_payload_i.channel_index == LAST_IDX)))
    else $error("last flag does not match final channel index");

  a_index_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_mid |=> out_valid_i &&
      (out_payload_i.channel_index == $past(out_payload_i.channel_index) + 1'b1))
    else $error("channel index did not advance within a report");

  a_report_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_mid |=> $stable(out_payload_i.error_total) && $stable(out_payload_i.frame_accepted)
      && $stable(out_payload_i.remote_active))
    else $error("report flags changed within one set of results");

endmodule

bind ibus_frame_decoder ibfd_checker #(
  .CHANNEL_COUNT (CHANNEL_COUNT)
) u_ibfd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_payload_i (out_o.payload)
);

### bench/testbench.sv
// Self-checking bench for ibus_frame_decoder: random framed byte streams, checked per channel.
// Depends on ibfd_pkg, ibfd_stream_if and the ibus_frame_decoder RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CHANNELS    = ibfd_pkg::CHANNEL_COUNT_DEFAULT;
  localparam int unsigned FRAME_LEN   = ibfd_pkg::FRAME_BYTES_DEFAULT;
  localparam int unsigned CFG_W       = ibfd_pkg::CFG_DATA_W;
  localparam int unsigned CLK_PERIOD  = 20;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [ibfd_pkg::COUNT_W-1:0] COUNT_CAP = '1;

  typedef enum int {
    FRAME_GOOD,
    FRAME_BAD_SUM,
    FRAME_SHORT,
    FRAME_LONG,
    FRAME_NOISE
  } frame_kind_e;

  typedef enum int {
    FILL_TYPICAL,
    FILL_MAX,
    FILL_ZERO,
    FILL_RANDOM
  } channel_fill_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_index_i = 1'b0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  logic req_valid = 1'b0;
  ibfd_pkg::in_item_t req_payload = '0;
  logic req_taken = 1'b0;
  logic result_ready = 1'b0;

  ibfd_stream_if #(.payload_t(ibfd_pkg::in_item_t)) in_if ();
  ibfd_stream_if #(.payload_t(ibfd_pkg::out_item_t)) out_if ();

  assign in_if.valid = req_valid;
  assign in_if.payload = req_payload;
  assign out_if.ready = result_ready;

  ibus_frame_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Decoder state as the bench sees it
  logic [ibfd_pkg::CH_SUM_W-1:0]  threshold = ibfd_pkg::THRESHOLD_RESET;
  logic [ibfd_pkg::CHANNEL_W-1:0] offset = ibfd_pkg::OFFSET_RESET;
  logic [ibfd_pkg::COUNT_W-1:0]   byte_count = '0;
  logic [ibfd_pkg::CHANNEL_W-1:0] running_sum = '0;
  logic [ibfd_pkg::CHANNEL_W-1:0] rx_checksum = '0;
  logic [ibfd_pkg::CHANNEL_W-1:0] shadow_words [CHANNELS];
  logic [ibfd_pkg::CHANNEL_W-1:0] stored_words [CHANNELS];
  logic [ibfd_pkg::CH_SUM_W-1:0]  stored_sum = '0;
  logic [ibfd_pkg::ERROR_W-1:0]   reject_count = '0;

  ibfd_pkg::in_item_t  pending_requests [$];
  ibfd_pkg::out_item_t expected_reports [$];

  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  int unsigned requests_taken = 0;
  int unsigned frame_ends = 0;
  int unsigned frames_accepted = 0;
  int unsigned results_checked = 0;
  int unsigned queued_total = 0;

  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  logic [7:0] stall_pattern = 8'hFF;
  logic [5:0] stall_age = '0;

  initial begin
    for (int i = 0; i < CHANNELS; i++) begin
      shadow_words[i] = '0;
      stored_words[i] = '0;
    end
  end

  function automatic void decode_request(ibfd_pkg::in_item_t req);
    logic accept;
    logic active;
    logic [ibfd_pkg::CH_SUM_W-1:0] sum;
    ibfd_pkg::out_item_t report;
    requests_taken++;
    if (req.operation == ibfd_pkg::OP_DATA_BYTE) begin
      if (byte_count != COUNT_CAP) begin
        if (byte_count < FRAME_LEN - 2)
          running_sum = running_sum + req.data_byte;
        if (byte_count >= 2 && byte_count < 2 + 2 * CHANNELS) begin
          if (!byte_count[0])
            shadow_words[(byte_count - 2) >> 1][7:0] = req.data_byte;
          else
            shadow_words[(byte_count - 2) >> 1][15:8] = req.data_byte;
        end
        if (byte_count == FRAME_LEN - 2) rx_checksum[7:0] = req.data_byte;
        if (byte_count == FRAME_LEN - 1) rx_checksum[15:8] = req.data_byte;
        byte_count = byte_count + 1'b1;
      end
    end else begin
      frame_ends++;
      accept = (byte_count == FRAME_LEN) && ((~running_sum) == rx_checksum);
      if (accept) begin
        frames_accepted++;
        sum = '0;
        for (int i = 0; i < CHANNELS; i++) begin
          stored_words[i] = shadow_words[i];
          sum = sum + stored_words[i];
        end
        stored_sum = sum;
      end else if (reject_count != '1) begin
        reject_count = reject_count + 1'b1;
      end
      byte_count = '0;
      running_sum = '0;
      active = stored_sum >= threshold;
      for (int i = 0; i < CHANNELS; i++) begin
        report.channel_index = i[ibfd_pkg::INDEX_W-1:0];
        report.channel_value = stored_words[i] - offset;
        report.remote_active = active;
        report.frame_accepted = accept;
        report.error_total = reject_count;
        report.last_channel = (i == CHANNELS - 1);
        expected_reports.push_back(report);
      end
    end
  endfunction

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count,
               expected_reports.size());
      $display("FAIL ibus_frame_decoder");
      $finish;
    end
  end

  // Request side: record the handshake, predict, then refill at the falling edge
  always @(posedge clk_i) begin
    req_taken <= req_valid && in_if.ready;
    if (rst_ni && req_valid && in_if.ready) decode_request(req_payload);
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!req_valid || req_taken)) begin
      if (gap_left != 0 || pending_requests.size() == 0) begin
        req_valid <= 1'b0;
        if (gap_left != 0) gap_left <= gap_left - 1;
      end else begin
        req_valid <= 1'b1;
        req_payload <= pending_requests.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Result side: rotate a stall pattern, reload it each time the 6-bit age counter wraps
  always @(negedge clk_i) begin
    stall_age <= stall_age + 1'b1;
    if (stall_age == 0)
      stall_pattern <= ($urandom_range(0, 3) == 0) ? 8'hFF :
                       (8'($urandom_range(0, 255)) | 8'h01);
    else
      stall_pattern <= {stall_pattern[6:0], stall_pattern[7]};
    result_ready <= stall_pattern[0];
  end

  always @(posedge clk_i) begin : result_check
    ibfd_pkg::out_item_t got;
    ibfd_pkg::out_item_t want;
    if (rst_ni && out_if.valid && result_ready) begin
      got = out_if.payload;
      results_checked++;
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: ch %0d value %h active %b ok %b errors %0d last %b",
                   got.channel_index, got.channel_value, got.remote_active,
                   got.frame_accepted, got.error_total, got.last_channel);
      end else begin
        want = expected_reports.pop_front();
        if (got.channel_index !== want.channel_index ||
            got.channel_value !== want.channel_value ||
            got.remote_active !== want.remote_active ||
            got.frame_accepted !== want.frame_accepted ||
            got.error_total !== want.error_total ||
            got.last_channel !== want.last_channel) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch at %0d: expected ch %0d value %h active %b ok %b ",
                      "errors %0d last %b, got ch %0d value %h active %b ok %b ",
                      "errors %0d last %b"}, cycle_count,
                     want.channel_index, want.channel_value, want.remote_active,
                     want.frame_accepted, want.error_total, want.last_channel,
                     got.channel_index, got.channel_value, got.remote_active,
                     got.frame_accepted, got.error_total, got.last_channel);
        end
      end
    end
  end

  task automatic queue_byte(logic [7:0] value);
    ibfd_pkg::in_item_t req;
    req.operation = ibfd_pkg::OP_DATA_BYTE;
    req.data_byte = value;
    pending_requests.push_back(req);
    queued_total++;
  endtask

  task automatic queue_marker();
    ibfd_pkg::in_item_t req;
    req.operation = ibfd_pkg::OP_END_OF_FRAME;
    req.data_byte = 8'($urandom_range(0, 255));
    pending_requests.push_back(req);
    queued_total++;
  endtask

  // Build one frame; length applies to short, long and noise frames
  task automatic queue_frame(frame_kind_e kind, channel_fill_e fill, int unsigned length);
    logic [7:0] frame [$];
    logic [ibfd_pkg::CHANNEL_W-1:0] word;
    logic [ibfd_pkg::CHANNEL_W-1:0] sum;
    if (kind == FRAME_NOISE) begin
      for (int i = 0; i < length; i++) frame.push_back(8'($urandom_range(0, 255)));
    end else begin
      frame.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : 8'h20);
      frame.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : 8'h40);
      for (int i = 0; i < CHANNELS; i++) begin
        case (fill)
          FILL_TYPICAL: word = 16'($urandom_range(1000, 2000));
          FILL_MAX:     word = '1;
          FILL_ZERO:    word = '0;
          default:      word = 16'($urandom_range(0, 65535));
        endcase
        frame.push_back(word[7:0]);
        frame.push_back(word[15:8]);
      end
      while (frame.size() < FRAME_LEN - 2) frame.push_back(8'($urandom_range(0, 255)));
      sum = '0;
      foreach (frame[i]) sum = sum + frame[i];
      sum = ~sum;
      if (kind == FRAME_BAD_SUM) sum = sum ^ 16'($urandom_range(1, 65535));
      frame.push_back(sum[7:0]);
      frame.push_back(sum[15:8]);
      if (kind == FRAME_SHORT)
        while (frame.size() > length) void'(frame.pop_back());
      if (kind == FRAME_LONG)
        while (frame.size() < length) frame.push_back(8'($urandom_range(0, 255)));
    end
    foreach (frame[i]) queue_byte(frame[i]);
    queue_marker();
  endtask

  task automatic write_register(ibfd_pkg::cfg_reg_e index, logic [CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (index == ibfd_pkg::REG_ACTIVE_THRESHOLD) threshold = value;
    else offset = value[ibfd_pkg::CHANNEL_W-1:0];
  endtask

  task automatic wait_idle();
    while (pending_requests.size() != 0 || req_valid || expected_reports.size() != 0)
      @(posedge clk_i);
    repeat (CHANNELS + 4) @(posedge clk_i);
  endtask

  initial begin
    int unsigned pick;
    channel_fill_e fill;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Empty frame, extreme bytes in a short frame, repeated marker
    queue_marker();
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(8'h80);
    queue_byte(8'h01);
    queue_byte(8'h7F);
    queue_marker();
    queue_marker();
    wait_idle();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_register(ibfd_pkg::REG_ACTIVE_THRESHOLD, '0);
          write_register(ibfd_pkg::REG_CHANNEL_OFFSET, '0);
          queue_frame(FRAME_LONG, FILL_TYPICAL, 64);
        end
        1: begin
          write_register(ibfd_pkg::REG_ACTIVE_THRESHOLD, 20'd655350);
          write_register(ibfd_pkg::REG_CHANNEL_OFFSET, 20'd65535);
          queue_frame(FRAME_GOOD, FILL_MAX, FRAME_LEN);
        end
        2: begin
          write_register(ibfd_pkg::REG_ACTIVE_THRESHOLD, CFG_W'($urandom_range(0, 655350)));
          write_register(ibfd_pkg::REG_CHANNEL_OFFSET, CFG_W'($urandom_range(0, 65535)));
          pick = $urandom_range(0, 9);
          fill = channel_fill_e'($urandom_range(0, 3));
          if (pick < 6) queue_frame(FRAME_GOOD, fill, FRAME_LEN);
          else if (pick == 6) queue_frame(FRAME_BAD_SUM, fill, FRAME_LEN);
          else if (pick == 7) queue_frame(FRAME_SHORT, fill, $urandom_range(0, FRAME_LEN - 1));
          else if (pick == 8) queue_frame(FRAME_LONG, fill, $urandom_range(FRAME_LEN + 1, 70));
          else queue_frame(FRAME_NOISE, fill, $urandom_range(0, 40));
        end
        default: begin
          write_register(ibfd_pkg::REG_ACTIVE_THRESHOLD, 20'd15000);
          write_register(ibfd_pkg::REG_CHANNEL_OFFSET, 20'd1000);
          queue_frame(FRAME_GOOD, FILL_TYPICAL, FRAME_LEN);
        end
      endcase
      wait_idle();
    end

    $display("run: %0d requests over 5 register settings, %0d frame ends, %0d accepted",
             requests_taken, frame_ends, frames_accepted);
    $display("run: %0d channel results checked, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("PASS ibus_frame_decoder");
    end else begin
      $display("FAIL ibus_frame_decoder");
    end
    $finish;
  end

endmodule
